>>> rtl/ambient_light_brightness_control_unit_defines.svh
// ---------------------------------------------------------------------------
// ambient light brightness control unit: assertion macros
// concurrent checks that can be compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef AMBIENT_LIGHT_BRIGHTNESS_CONTROL_UNIT_DEFINES_SVH
`define AMBIENT_LIGHT_BRIGHTNESS_CONTROL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define ALBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ALBC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALBC_ASSERT(lbl, prop, msg)
`define ALBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/albc_pkg.sv
// ---------------------------------------------------------------------------
// albc_pkg
// widths, register indexes, codes and the log lookup of the brightness unit
// ---------------------------------------------------------------------------
package albc_pkg;

	localparam int WINDOW = 10;

	localparam int LUX_W   = 21;
	localparam int THR_W   = 17;
	localparam int INT_W   = 4;
	localparam int CODE_W  = 8;
	localparam int TERM_W  = 10;
	localparam int PROD_W  = TERM_W + INT_W;
	localparam int SMP_W   = 4;
	localparam int SMP_MAX = 15;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(WINDOW * SMP_MAX + WINDOW / 2 + 1);
	localparam int ITER_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = THR_W;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_INTENSITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_THR       = 2'd2;

	localparam logic [INT_W-1:0] RST_MAX_INTENSITY = 4'd15;
	localparam logic [THR_W-1:0] RST_BRIGHT_THR    = 17'd40000;
	localparam logic [THR_W-1:0] RST_DIM_THR       = 17'd10;

	localparam logic [CODE_W-1:0] CODE_NONE   = 8'd0;
	localparam logic [CODE_W-1:0] CODE_BRIGHT = 8'd32;
	localparam logic [CODE_W-1:0] CODE_NORMAL = 8'd69;
	localparam logic [CODE_W-1:0] CODE_DIM    = 8'd138;

	localparam logic [LUX_W-1:0]  LOG_FIRST = 21'd16;
	localparam logic [LUX_W-1:0]  LOG_LAST  = 21'd160;
	localparam logic [TERM_W-1:0] TERM_FULL = 10'd1000;
	localparam int                TERM_DIV  = 1000;

	// floor(1000*log10(n/16)) for n from 16 to 159
	function automatic logic [TERM_W-1:0] albc_log_term(input logic [7:0] n);
		logic [TERM_W-1:0] t;
		case (n)
			8'd16:  t = 10'd0;   8'd17:  t = 10'd26;  8'd18:  t = 10'd51;  8'd19:  t = 10'd74;
			8'd20:  t = 10'd96;  8'd21:  t = 10'd118; 8'd22:  t = 10'd138; 8'd23:  t = 10'd157;
			8'd24:  t = 10'd176; 8'd25:  t = 10'd193; 8'd26:  t = 10'd210; 8'd27:  t = 10'd227;
			8'd28:  t = 10'd243; 8'd29:  t = 10'd258; 8'd30:  t = 10'd273; 8'd31:  t = 10'd287;
			8'd32:  t = 10'd301; 8'd33:  t = 10'd314; 8'd34:  t = 10'd327; 8'd35:  t = 10'd339;
			8'd36:  t = 10'd352; 8'd37:  t = 10'd364; 8'd38:  t = 10'd375; 8'd39:  t = 10'd386;
			8'd40:  t = 10'd397; 8'd41:  t = 10'd408; 8'd42:  t = 10'd419; 8'd43:  t = 10'd429;
			8'd44:  t = 10'd439; 8'd45:  t = 10'd449; 8'd46:  t = 10'd458; 8'd47:  t = 10'd467;
			8'd48:  t = 10'd477; 8'd49:  t = 10'd486; 8'd50:  t = 10'd494; 8'd51:  t = 10'd503;
			8'd52:  t = 10'd511; 8'd53:  t = 10'd520; 8'd54:  t = 10'd528; 8'd55:  t = 10'd536;
			8'd56:  t = 10'd544; 8'd57:  t = 10'd551; 8'd58:  t = 10'd559; 8'd59:  t = 10'd566;
			8'd60:  t = 10'd574; 8'd61:  t = 10'd581; 8'd62:  t = 10'd588; 8'd63:  t = 10'd595;
			8'd64:  t = 10'd602; 8'd65:  t = 10'd608; 8'd66:  t = 10'd615; 8'd67:  t = 10'd621;
			8'd68:  t = 10'd628; 8'd69:  t = 10'd634; 8'd70:  t = 10'd640; 8'd71:  t = 10'd647;
			8'd72:  t = 10'd653; 8'd73:  t = 10'd659; 8'd74:  t = 10'd665; 8'd75:  t = 10'd670;
			8'd76:  t = 10'd676; 8'd77:  t = 10'd682; 8'd78:  t = 10'd687; 8'd79:  t = 10'd693;
			8'd80:  t = 10'd698; 8'd81:  t = 10'd704; 8'd82:  t = 10'd709; 8'd83:  t = 10'd714;
			8'd84:  t = 10'd720; 8'd85:  t = 10'd725; 8'd86:  t = 10'd730; 8'd87:  t = 10'd735;
			8'd88:  t = 10'd740; 8'd89:  t = 10'd745; 8'd90:  t = 10'd750; 8'd91:  t = 10'd754;
			8'd92:  t = 10'd759; 8'd93:  t = 10'd764; 8'd94:  t = 10'd769; 8'd95:  t = 10'd773;
			8'd96:  t = 10'd778; 8'd97:  t = 10'd782; 8'd98:  t = 10'd787; 8'd99:  t = 10'd791;
			8'd100: t = 10'd795; 8'd101: t = 10'd800; 8'd102: t = 10'd804; 8'd103: t = 10'd808;
			8'd104: t = 10'd812; 8'd105: t = 10'd817; 8'd106: t = 10'd821; 8'd107: t = 10'd825;
			8'd108: t = 10'd829; 8'd109: t = 10'd833; 8'd110: t = 10'd837; 8'd111: t = 10'd841;
			8'd112: t = 10'd845; 8'd113: t = 10'd848; 8'd114: t = 10'd852; 8'd115: t = 10'd856;
			8'd116: t = 10'd860; 8'd117: t = 10'd864; 8'd118: t = 10'd867; 8'd119: t = 10'd871;
			8'd120: t = 10'd875; 8'd121: t = 10'd878; 8'd122: t = 10'd882; 8'd123: t = 10'd885;
			8'd124: t = 10'd889; 8'd125: t = 10'd892; 8'd126: t = 10'd896; 8'd127: t = 10'd899;
			8'd128: t = 10'd903; 8'd129: t = 10'd906; 8'd130: t = 10'd909; 8'd131: t = 10'd913;
			8'd132: t = 10'd916; 8'd133: t = 10'd919; 8'd134: t = 10'd922; 8'd135: t = 10'd926;
			8'd136: t = 10'd929; 8'd137: t = 10'd932; 8'd138: t = 10'd935; 8'd139: t = 10'd938;
			8'd140: t = 10'd942; 8'd141: t = 10'd945; 8'd142: t = 10'd948; 8'd143: t = 10'd951;
			8'd144: t = 10'd954; 8'd145: t = 10'd957; 8'd146: t = 10'd960; 8'd147: t = 10'd963;
			8'd148: t = 10'd966; 8'd149: t = 10'd969; 8'd150: t = 10'd971; 8'd151: t = 10'd974;
			8'd152: t = 10'd977; 8'd153: t = 10'd980; 8'd154: t = 10'd983; 8'd155: t = 10'd986;
			8'd156: t = 10'd989; 8'd157: t = 10'd991; 8'd158: t = 10'd994; 8'd159: t = 10'd997;
			default: t = 10'd0;
		endcase
		return t;
	endfunction

	// floor(p/1000) for p up to 15000, by independent threshold compares
	function automatic logic [SMP_W-1:0] albc_div_term(input logic [PROD_W-1:0] p);
		logic [SMP_W-1:0] s;
		s = '0;
		for (int k = 1; k <= SMP_MAX; k++) begin
			if (p >= PROD_W'(k * TERM_DIV))
				s = s + SMP_W'(1);
		end
		return s;
	endfunction

endpackage

>>> rtl/ambient_light_brightness_control_unit.sv
// ---------------------------------------------------------------------------
// ambient_light_brightness_control_unit
// lux reading to display brightness with range selection and moving average
// ---------------------------------------------------------------------------
// One input beat yields one output beat. The unit works on one reading at a
// time: after acceptance a beat passes the multiply, sample and update steps
// and the 8-step restoring divider that forms the rounded average.
// The next reading is taken as soon as the previous result sits in the output
// register, even if the consumer has not taken it yet. The sample history
// lives in a small synchronous memory read at acceptance and written back
// once per beat; it needs no clearing pass after reset. Configuration writes
// take effect at once and are expected only while no beat is in flight.
`include "ambient_light_brightness_control_unit_defines.svh"

module ambient_light_brightness_control_unit
	import albc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LUX_W-1:0]      lux_sixteenths,
	input  logic                  sensor_error,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [INT_W-1:0]      intensity,
	output logic                  range_update,
	output logic [CODE_W-1:0]     range_code
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SMP  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]        state_q;
	logic [INT_W-1:0]  max_int_q;
	logic [THR_W-1:0]  bright_thr_q;
	logic [THR_W-1:0]  dim_thr_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;

	logic [TERM_W-1:0] term_q;
	logic [PROD_W-1:0] prod_q;
	logic [SMP_W-1:0]  sample_q;
	logic              update_q;
	logic [CODE_W-1:0] code_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  rem_q;
	logic [INT_W-1:0]  intensity_q;
	logic              range_update_q;
	logic [CODE_W-1:0] range_code_q;

	logic [SMP_W-1:0]  ring_mem [WINDOW];
	logic [SMP_W-1:0]  ring_rd_q;

	logic              accept;
	logic              ring_we;
	logic              out_load;
	logic [TERM_W-1:0] term_d;
	logic [CODE_W-1:0] code_d;
	logic              full;
	logic [SUM_W-1:0]  sum_d;
	logic [CNT_W-1:0]  cnt_d;
	logic [SLOT_W-1:0] slot_d;
	logic [CNT_W:0]    rem_shift;
	logic              q_bit;
	logic [CNT_W-1:0]  rem_d;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign ring_we  = (state_q == ST_UPD);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// range code and log term straight from the input beat
	always_comb begin
		if (lux_sixteenths > {bright_thr_q, 4'b0000})
			code_d = CODE_BRIGHT;
		else if (lux_sixteenths > {dim_thr_q, 4'b0000})
			code_d = CODE_NORMAL;
		else
			code_d = CODE_DIM;
		if (sensor_error)
			code_d = CODE_NONE;

		if (sensor_error || lux_sixteenths < LOG_FIRST)
			term_d = '0;
		else if (lux_sixteenths >= LOG_LAST)
			term_d = TERM_FULL;
		else
			term_d = albc_log_term(lux_sixteenths[7:0]);
	end

	// running sum and fill count update
	always_comb begin
		full = (cnt_q == CNT_W'(WINDOW));
		if (full) begin
			sum_d = sum_q - SUM_W'(ring_rd_q) + SUM_W'(sample_q);
			cnt_d = cnt_q;
		end else begin
			sum_d = sum_q + SUM_W'(sample_q);
			cnt_d = cnt_q + CNT_W'(1);
		end
		if (slot_q == SLOT_W'(WINDOW - 1))
			slot_d = '0;
		else
			slot_d = slot_q + SLOT_W'(1);
	end

	// one restoring divide step, quotient shifts into the dividend register
	always_comb begin
		rem_shift = {rem_q, dvd_q[SUM_W-1]};
		q_bit     = (rem_shift >= {1'b0, dvs_q});
		if (q_bit)
			rem_d = CNT_W'(rem_shift - {1'b0, dvs_q});
		else
			rem_d = rem_shift[CNT_W-1:0];
	end

	// sample history memory, read at acceptance, written in the update step
	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[slot_q] <= sample_q;
		if (accept)
			ring_rd_q <= ring_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_int_q    <= RST_MAX_INTENSITY;
			bright_thr_q <= RST_BRIGHT_THR;
			dim_thr_q    <= RST_DIM_THR;
			sum_q        <= '0;
			cnt_q        <= '0;
			slot_q       <= '0;
			iter_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_INTENSITY: max_int_q    <= cfg_wdata[INT_W-1:0];
					REG_BRIGHT_THR:    bright_thr_q <= cfg_wdata[THR_W-1:0];
					REG_DIM_THR:       dim_thr_q    <= cfg_wdata[THR_W-1:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_SMP;
				ST_SMP: state_q <= ST_UPD;
				ST_UPD: begin
					sum_q   <= sum_d;
					cnt_q   <= cnt_d;
					slot_q  <= slot_d;
					iter_q  <= ITER_W'(SUM_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (iter_q == '0)
						state_q <= ST_OUT;
					else
						iter_q <= iter_q - ITER_W'(1);
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			term_q   <= term_d;
			update_q <= !sensor_error;
			code_q   <= code_d;
		end
		if (state_q == ST_MUL)
			prod_q <= PROD_W'(term_q) * PROD_W'(max_int_q);
		if (state_q == ST_SMP)
			sample_q <= albc_div_term(prod_q);
		if (state_q == ST_UPD) begin
			dvd_q <= sum_d + SUM_W'(cnt_d >> 1);
			dvs_q <= cnt_d;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
			rem_q <= rem_d;
		end
		if (out_load) begin
			intensity_q    <= dvd_q[INT_W-1:0];
			range_update_q <= update_q;
			range_code_q   <= code_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign intensity    = intensity_q;
	assign range_update = range_update_q;
	assign range_code   = range_code_q;

	`ALBC_ASSERT_ALWAYS(a_slot_range, !arst_n || slot_q < SLOT_W'(WINDOW), "write slot out of range")
	`ALBC_ASSERT(a_one_beat, accept |=> !in_ready, "second beat taken while one is in flight")
	`ALBC_ASSERT(a_cnt_range, cnt_q <= CNT_W'(WINDOW), "fill count beyond window")
	`ALBC_ASSERT(a_sum_bound, 12'(sum_q) <= 12'(cnt_q) * 12'(SMP_MAX), "sum exceeds filled samples")
	`ALBC_ASSERT(a_out_after_div, $rose(out_valid_q) |-> $past(state_q) == ST_OUT, "result not from divider")

endmodule

>>> tb/albc_brightness_checker.sv
// ---------------------------------------------------------------------------
// albc_brightness_checker
// Watches both beat channels and the register port of the brightness unit.
// Keeps its own copy of the registers and the sample history, predicts the
// range code and averaged intensity of every accepted reading, and compares
// every output beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module albc_brightness_checker
	import albc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [LUX_W-1:0]      lux_sixteenths,
	input  logic                  sensor_error,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [INT_W-1:0]      intensity,
	input  logic                  range_update,
	input  logic [CODE_W-1:0]     range_code,
	output int                    fail_count,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [INT_W-1:0]  intensity;
		logic              range_update;
		logic [CODE_W-1:0] range_code;
	} light_result_t;

	light_result_t    expected_levels[$];
	logic [INT_W-1:0] max_intensity_r;
	logic [THR_W-1:0] bright_thr_r;
	logic [THR_W-1:0] dim_thr_r;
	logic [SMP_W-1:0] history[WINDOW];
	int               history_sum;
	int               history_count;
	int               history_slot;
	int               mismatches;

	// floor(1000*log10(lux/16)); only exact at lux 16, irrational elsewhere
	function automatic int log_term(input logic [LUX_W-1:0] lux);
		real r;
		if (lux >= LOG_LAST)
			return TERM_DIV;
		if (lux < LOG_FIRST)
			return 0;
		r = 1000.0 * $ln(real'(int'(lux)) / 16.0) / $ln(10.0);
		return int'($floor(r));
	endfunction

	function automatic light_result_t predict_level(input logic [LUX_W-1:0] lux,
			input logic err);
		light_result_t res;
		int term;
		int sample;
		res.range_update = !err;
		res.range_code = CODE_NONE;
		term = 0;
		if (!err) begin
			if (int'(lux) > int'(bright_thr_r) * 16)
				res.range_code = CODE_BRIGHT;
			else if (int'(lux) > int'(dim_thr_r) * 16)
				res.range_code = CODE_NORMAL;
			else
				res.range_code = CODE_DIM;
			term = log_term(lux);
		end
		sample = term * int'(max_intensity_r) / TERM_DIV;
		if (history_count < WINDOW) begin
			history_count++;
			history_sum += sample;
		end else begin
			history_sum = history_sum - int'(history[history_slot]) + sample;
		end
		history[history_slot] = SMP_W'(sample);
		history_slot = (history_slot + 1) % WINDOW;
		res.intensity = INT_W'((history_sum + history_count / 2) / history_count);
		return res;
	endfunction

	task automatic flag_mismatch(input bit has_want, input light_result_t want,
			input light_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (has_want)
				$display("%0t: beat mismatch: expected intensity %0d update %0b code %0d, got intensity %0d update %0b code %0d",
					$time, want.intensity, want.range_update, want.range_code,
					got.intensity, got.range_update, got.range_code);
			else
				$display("%0t: output beat with none expected: got intensity %0d update %0b code %0d",
					$time, got.intensity, got.range_update, got.range_code);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		light_result_t got;
		light_result_t want;
		if (!arst_n) begin
			max_intensity_r = RST_MAX_INTENSITY;
			bright_thr_r = RST_BRIGHT_THR;
			dim_thr_r = RST_DIM_THR;
			for (int i = 0; i < WINDOW; i++)
				history[i] = '0;
			history_sum = 0;
			history_count = 0;
			history_slot = 0;
			mismatches = 0;
			expected_levels.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_INTENSITY: max_intensity_r = cfg_wdata[INT_W-1:0];
					REG_BRIGHT_THR:    bright_thr_r = cfg_wdata[THR_W-1:0];
					REG_DIM_THR:       dim_thr_r = cfg_wdata[THR_W-1:0];
					default:           ;
				endcase
			end
			if (in_valid && in_ready)
				expected_levels.push_back(predict_level(lux_sixteenths, sensor_error));
			if (out_valid && out_ready) begin
				got.intensity = intensity;
				got.range_update = range_update;
				got.range_code = range_code;
				if (expected_levels.size() == 0) begin
					flag_mismatch(1'b0, got, got);
				end else begin
					want = expected_levels.pop_front();
					if (got.intensity !== want.intensity
							|| got.range_update !== want.range_update
							|| got.range_code !== want.range_code)
						flag_mismatch(1'b1, want, got);
				end
			end
			fail_count <= mismatches;
			outstanding <= expected_levels.size();
		end
	end

endmodule

>>> tb/tb_ambient_light_brightness_control_unit.sv
// ---------------------------------------------------------------------------
// tb_ambient_light_brightness_control_unit
// Drives lux readings into the brightness unit under several register
// settings: a directed pass over the log range, threshold edges, errors and
// field extremes, then random phases with random gaps, receiver stalls, one
// long receiver hold and one stretch without any idling. The checker beside
// the unit predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_ambient_light_brightness_control_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import albc_pkg::*;

	localparam int LIMIT_CYCLES  = 300000;
	localparam int PHASE_ITEMS   = 100;
	localparam int RANDOM_PHASES = 5;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int LUX_MAX       = (1 << LUX_W) - 1;
	localparam int THR_MAX       = (1 << THR_W) - 1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [LUX_W-1:0]      lux_sixteenths = '0;
	logic                  sensor_error = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [INT_W-1:0]      intensity;
	logic                  range_update;
	logic [CODE_W-1:0]     range_code;
	int                    fail_count;
	int                    outstanding;

	int cycles = 0;
	int cur_bright = RST_BRIGHT_THR;
	int cur_dim = RST_DIM_THR;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int hold_req = 0;

	ambient_light_brightness_control_unit u_top (.*);
	albc_brightness_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT_CYCLES)
			@(posedge clk) cycles++;
		$display("tb_ambient_light_brightness_control_unit: errors");
		$finish;
	end

	// consumer: random stalls, a steady stretch, and long holds on request
	initial begin
		int stall;
		int holds_seen;
		int r;
		stall = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_seen) begin
				holds_seen = hold_req;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [LUX_W-1:0] pick_lux();
		int r;
		int t;
		r = $urandom_range(0, 99);
		if (r < 10)
			return LUX_W'($urandom_range(0, 15));
		if (r < 40)
			return LUX_W'($urandom_range(16, 159));
		if (r < 55)
			return LUX_W'($urandom_range(160, 4000));
		if (r < 75) begin
			t = ($urandom_range(0, 1) ? cur_bright : cur_dim) * 16
				+ int'($urandom_range(0, 2)) - 1;
			if (t < 0)
				t = 0;
			if (t > LUX_MAX)
				t = LUX_MAX;
			return LUX_W'(t);
		end
		return LUX_W'($urandom_range(0, LUX_MAX));
	endfunction

	task automatic send_reading(input int lux, input bit err);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		lux_sixteenths <= LUX_W'(lux);
		sensor_error <= err;
		do @(posedge clk); while (!in_ready);
	endtask

	// wait on the clock first so the count includes the beat just accepted
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// upper data bits beyond the intensity field are junk on purpose
	task automatic set_config(input int max_i, input int bright, input int dim);
		write_reg(REG_MAX_INTENSITY, int'($urandom & ~32'hF) | max_i);
		write_reg(REG_BRIGHT_THR, bright);
		write_reg(REG_DIM_THR, dim);
		write_reg(REG_UNMAPPED, int'($urandom));
		cur_bright = bright;
		cur_dim = dim;
	endtask

	initial begin
		int max_i;
		int bright;
		int dim;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_reading(0, 1'b0);
		send_reading(15, 1'b0);
		send_reading(16, 1'b0);
		send_reading(17, 1'b0);
		send_reading(32, 1'b0);
		send_reading(159, 1'b0);
		send_reading(160, 1'b0);
		send_reading(161, 1'b0);
		send_reading(640000, 1'b0);
		send_reading(640001, 1'b0);
		send_reading(LUX_MAX, 1'b0);
		send_reading(LUX_MAX, 1'b1);
		send_reading(0, 1'b1);
		wait_idle();

		set_config(15, THR_MAX, 0);
		send_reading(LUX_MAX, 1'b0);
		send_reading(THR_MAX * 16, 1'b0);
		send_reading(THR_MAX * 16 + 1, 1'b0);
		send_reading(1, 1'b0);
		send_reading(0, 1'b0);
		wait_idle();

		set_config(0, 0, 0);
		send_reading(100, 1'b0);
		send_reading(0, 1'b0);
		send_reading(LUX_MAX, 1'b0);
		send_reading(5, 1'b1);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 3))
				0:       max_i = 0;
				1:       max_i = 15;
				default: max_i = $urandom_range(0, 15);
			endcase
			case ($urandom_range(0, 4))
				0: begin
					bright = THR_MAX;
					dim = 0;
				end
				1: begin
					bright = $urandom_range(0, THR_MAX);
					dim = $urandom_range(0, THR_MAX);
				end
				default: begin
					dim = $urandom_range(0, 300);
					bright = $urandom_range(dim, dim + 5000);
				end
			endcase
			set_config(max_i, bright, dim);
			tx_steady = (p == 2);
			rx_steady = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 3 && i == 20)
					hold_req++;
				send_reading(pick_lux(), $urandom_range(0, 9) == 0);
			end
			wait_idle();
		end

		if (fail_count == 0 && outstanding == 0)
			$display("tb_ambient_light_brightness_control_unit: clean");
		else
			$display("tb_ambient_light_brightness_control_unit: errors");
		$finish;
	end

endmodule
